// ----- sv/itda_pkg.sv -----
// Shared types, character codes and the power-of-ten multiple table for the
// integer-to-decimal-ASCII unit. No dependencies.
package itda_pkg;

    localparam int unsigned WORD_W          = 32;
    localparam int unsigned CHAR_W          = 8;
    localparam int unsigned POS_W           = 4;
    localparam int unsigned NUM_DIGITS      = 10;
    localparam int unsigned TAB_W           = 34;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Highest digit position (units = 0) of a 32-bit magnitude
    localparam logic [POS_W-1:0] POS_MAX = 4'd9;

    // One converted job: sign, magnitude and position of its leading digit
    typedef struct packed {
        logic                neg;
        logic [WORD_W-1:0]   mag;
        logic [POS_W-1:0]    pos;
    } t_job;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Row = digit position, column = multiplier 0..9; value k * 10^row.
    // Rows past the last position saturate so no compare ever passes.
    typedef logic [15:0][NUM_DIGITS-1:0][TAB_W-1:0] t_mult_tab;

    function automatic t_mult_tab build_mult_tab();
        t_mult_tab          tab;
        logic [TAB_W-1:0]   p;
        p = 34'd1;
        for (int r = 0; r < 16; r++) begin
            for (int k = 0; k < 10; k++) begin
                tab[r][k] = (r < 10) ? p * TAB_W'(k) : '1;
            end
            p = p * 34'd10;
        end
        return tab;
    endfunction

    localparam t_mult_tab MULT_TAB = build_mult_tab();

endpackage

// ----- sv/itda_front.sv -----
// Front end: accepts words, forms sign and magnitude and finds the leading
// digit position. Depends on itda_pkg.
module itda_front (
    input  logic                  i_valid,
    input  logic [31:0]           i_value,
    input  logic                  i_is_signed,
    input  itda_pkg::t_q_status   i_q_status,
    output logic                  o_stall,
    output logic                  o_push,
    output itda_pkg::t_job        o_job
);
    import itda_pkg::*;

    logic                neg;
    logic [WORD_W-1:0]   mag;
    logic [POS_W-1:0]    pos;

    // Stall while the queue has no room
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Split sign from magnitude; the most negative word wraps to 2^31
    assign neg = i_is_signed && i_value[WORD_W-1];
    assign mag = neg ? (~i_value + 32'd1) : i_value;

    // Count powers of ten not above the magnitude to place the leading digit
    always_comb begin
        pos = '0;
        for (int p = 1; p < NUM_DIGITS; p++) begin
            if ({2'b00, mag} >= MULT_TAB[p][1]) begin
                pos = pos + 4'd1;
            end
        end
    end

    assign o_job = '{neg: neg, mag: mag, pos: pos};

endmodule

// ----- sv/itda_queue.sv -----
// Short job queue between the front and back ends.
// Depends on itda_pkg for the job type.
module itda_queue #(
    parameter int unsigned DEPTH = itda_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  itda_pkg::t_job        i_job,
    input  logic                  i_pop,
    output itda_pkg::t_job        o_job,
    output itda_pkg::t_q_status   o_status
);
    import itda_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/itda_back.sv -----
// Back end: pulls jobs from the queue and emits a minus sign for negative numbers and then
// one decimal digit per cycle while output is not stalled, leading digit first. Depends on itda_pkg.
module itda_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  itda_pkg::t_job        i_job,
    input  itda_pkg::t_q_status   i_q_status,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [7:0]            o_char_code,
    output logic                  o_last
);
    import itda_pkg::*;

    logic                r_busy;
    logic                r_sign;
    logic [WORD_W-1:0]   r_mag;
    logic [POS_W-1:0]    r_pos;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    logic                step;
    logic                final_char;
    logic [POS_W-1:0]    digit;
    logic [WORD_W-1:0]   n_mag;
    logic [CHAR_W-1:0]   n_char;
    logic                n_last;
    logic [TAB_W-1:0]    sub_val;

    // Find the digit at the current position: count multiples not above
    always_comb begin
        digit = '0;
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if ({2'b00, r_mag} >= MULT_TAB[r_pos][k]) begin
                digit = digit + 4'd1;
            end
        end
    end

    assign sub_val = MULT_TAB[r_pos][digit];
    assign n_mag   = r_mag - sub_val[WORD_W-1:0];

    // Pick the next character
    assign final_char = !r_sign && (r_pos == '0);
    assign n_char     = r_sign ? ASCII_MINUS : (ASCII_ZERO + {4'b0000, digit});
    assign n_last     = final_char;

    // Advance when a job is active and the output register is free
    assign step  = r_busy && (!r_out_valid || !i_stall);
    assign o_pop = !i_q_status.empty && (!r_busy || (step && final_char));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Output register: load a new character or drop a taken one
            if (step) begin
                r_out_valid <= 1'b1;
                r_char      <= n_char;
                r_last      <= n_last;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            // Job register: load from queue or walk down the digits
            if (o_pop) begin
                r_busy <= 1'b1;
                r_sign <= i_job.neg;
                r_mag  <= i_job.mag;
                r_pos  <= i_job.pos;
            end else if (step) begin
                if (r_sign) begin
                    r_sign <= 1'b0;
                end else begin
                    r_mag <= n_mag;
                    r_pos <= r_pos - 4'd1;
                    if (r_pos == '0) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // A minus sign never ends a number
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_char_code == ASCII_MINUS)) |-> !o_last)
        else $error("minus sign flagged as last character");

    // Output is always a minus sign or a decimal digit
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_code == ASCII_MINUS) ||
                     ((o_char_code >= ASCII_ZERO) && (o_char_code <= ASCII_NINE))))
        else $error("character outside digit and sign set");

    // Active digit position stays inside a 32-bit magnitude
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos <= POS_MAX))
        else $error("digit position out of range");

    // A finished job with nothing queued leaves the back end idle
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && final_char && i_q_status.empty) |=> !r_busy)
        else $error("back end stayed busy after final character");

endmodule

// ----- sv/int_to_decimal_ascii_unit.sv -----
// Converts a 32-bit word, signed or unsigned, into its decimal ASCII text,
// one character per output item, leading digit first, with o_last on the
// final character. A number has 1 to 11 characters, and the back end's digit extractor
// produces one character per cycle while output is not stalled. A taken word passes
// through the job queue, the back end's job register and its output register; while
// output is not stalled, the characters of queued numbers follow each other
// with no gap, and a short job queue lets new words enter while a number is
// still being emitted.
// Depends on itda_pkg, itda_front, itda_queue and itda_back.
module int_to_decimal_ascii_unit #(
    parameter int unsigned QUEUE_DEPTH = itda_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [31:0]  i_value,
    input  logic         i_is_signed,
    output logic         o_stall,
    output logic         o_valid,
    output logic [7:0]   o_char_code,
    output logic         o_last,
    input  logic         i_stall
);
    import itda_pkg::*;

    t_job        push_job;
    t_job        head_job;
    t_q_status   q_status;
    logic        push;
    logic        pop;

    // Classify incoming words
    itda_front u_front (
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_is_signed (i_is_signed),
        .i_q_status  (q_status),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Decouple front and back
    itda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // Emit characters
    itda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

// ----- test/tb_int_to_decimal_ascii_unit.sv -----
`timescale 1ns / 1ps
// Testbench for int_to_decimal_ascii_unit: drives 32-bit words under bursty valid and
// patterned output stall, predicts the decimal ASCII text and checks every character.
// Depends on itda_pkg and the int_to_decimal_ascii_unit RTL.
module tb_int_to_decimal_ascii_unit;
    import itda_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_WORDS  = 310;
    localparam int DECIMAL_BASE  = 10;
    localparam int MAX_STALL_RUN = 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } t_stall_mode;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              is_signed;
    } t_word_req;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [31:0]       i_value = '0;
    logic              i_is_signed = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [7:0]        o_char_code;
    logic              o_last;
    logic              i_stall = 1'b0;

    t_word_req         pending_words[$];
    t_text_char        expected_text[$];
    int                mismatches = 0;
    int                quiet_cycles = 0;

    // Driver bookkeeping
    t_word_req         next_word;
    int                burst_left = 1;
    int                gap_left = 0;

    // Receiver bookkeeping
    t_text_char        want;
    t_stall_mode       stall_mode = STALL_NONE;
    int                mode_left = 0;
    int                stall_run = 0;
    logic              stall_next;

    int_to_decimal_ascii_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_is_signed (i_is_signed),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .i_stall     (i_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint pow_ten(input int n);
        longint p;
        p = 1;
        for (int k = 0; k < n; k++) p = p * DECIMAL_BASE;
        return p;
    endfunction

    // Append the decimal text of one word to the expected characters
    function automatic void predict_text(input logic [31:0] word, input logic as_signed);
        logic              neg;
        logic [31:0]       mag;
        logic [3:0]        digs [10];
        logic [CHAR_W-1:0] ch;
        int                n;
        neg = as_signed && word[31];
        mag = neg ? (~word + 32'd1) : word;
        n = 0;
        do begin
            digs[n] = 4'(mag % DECIMAL_BASE);
            mag = mag / DECIMAL_BASE;
            n++;
        end while (mag != 0);
        if (neg) expected_text.push_back('{code: ASCII_MINUS, last: 1'b0});
        for (int d = n - 1; d >= 0; d--) begin
            ch = ASCII_ZERO + CHAR_W'(digs[d]);
            expected_text.push_back('{code: ch, last: (d == 0)});
        end
    endfunction

    task automatic add_word(input logic [31:0] value, input logic as_signed);
        pending_words.push_back('{value: value, is_signed: as_signed});
    endtask

    // Sender: present queued words in bursts, hold the item while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_text(i_value, i_is_signed);
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    next_word = pending_words.pop_front();
                    i_valid <= 1'b1;
                    i_value <= next_word.value;
                    i_is_signed <= next_word.is_signed;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(12, 1);
                        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted character, then pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_text.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected char %h last %b, nothing pending",
                                 o_char_code, o_last);
                end else begin
                    want = expected_text.pop_front();
                    if (o_char_code !== want.code || o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("char mismatch: expected %h last %b, got %h last %b",
                                     want.code, want.last, o_char_code, o_last);
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(3, 0));
                mode_left = $urandom_range(80, 20);
            end else begin
                mode_left = mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  stall_next = 1'b0;
                STALL_LIGHT: stall_next = ($urandom_range(9, 0) < 2);
                STALL_HEAVY: stall_next = ($urandom_range(9, 0) < 7);
                default:     stall_next = (mode_left % 3 == 0);
            endcase
            // Cap stall runs so the sender always drains
            if (stall_run >= MAX_STALL_RUN) stall_next = 1'b0;
            stall_run = stall_next ? stall_run + 1 : 0;
            i_stall <= stall_next;
        end
    end

    // Count cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_word_req   req;
        longint      lo;
        longint      hi;
        logic [31:0] mag;
        logic [31:0] base;
        int          n;

        // Directed: zero, digit-count boundaries, sign extremes
        add_word(32'd0, 1'b0);
        add_word(32'd0, 1'b1);
        add_word(32'd1, 1'b0);
        add_word(32'd9, 1'b1);
        add_word(32'd10, 1'b0);
        add_word(32'd99, 1'b1);
        add_word(32'd100, 1'b0);
        add_word(32'd12345, 1'b1);
        add_word(32'd999999999, 1'b1);
        add_word(32'd1000000000, 1'b0);
        add_word(32'h7FFFFFFF, 1'b1);
        add_word(32'h7FFFFFFF, 1'b0);
        add_word(32'h80000000, 1'b1);
        add_word(32'h80000000, 1'b0);
        add_word(32'h80000001, 1'b1);
        add_word(32'hFFFFFFFF, 1'b0);
        add_word(32'hFFFFFFFF, 1'b1);
        add_word(32'hFFFFFFF6, 1'b1);
        add_word(32'hFFFFFFF6, 1'b0);
        add_word(32'd4000000000, 1'b0);
        add_word(32'hC4653600, 1'b1);

        // Random: mix of raw words, sized magnitudes, small values and edges
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            req.is_signed = 1'($urandom_range(1, 0));
            case ($urandom_range(9, 0))
                0, 1: begin
                    req.value = $urandom;
                end
                2, 3, 4, 5: begin
                    n = $urandom_range(10, 1);
                    lo = (n == 1) ? 0 : pow_ten(n - 1);
                    hi = pow_ten(n) - 1;
                    if (hi > 64'hFFFFFFFF) hi = 64'hFFFFFFFF;
                    mag = $urandom_range(hi[31:0], lo[31:0]);
                    if (req.is_signed && $urandom_range(1, 0) == 1 && mag <= 32'h80000000)
                        req.value = ~mag + 32'd1;
                    else
                        req.value = mag;
                end
                6, 7: begin
                    mag = $urandom_range(20, 0);
                    req.value = (req.is_signed && $urandom_range(1, 0) == 1) ?
                                (~mag + 32'd1) : mag;
                end
                8: begin
                    n = $urandom_range(9, 1);
                    base = 32'(pow_ten(n));
                    req.value = base + $urandom_range(2, 0) - 32'd1;
                end
                default: begin
                    case ($urandom_range(2, 0))
                        0:       base = 32'h80000000;
                        1:       base = 32'h7FFFFFFF;
                        default: base = 32'hFFFFFFFF;
                    endcase
                    req.value = base + $urandom_range(2, 0) - 32'd1;
                end
            endcase
            pending_words.push_back(req);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is taken and every character has come back
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || expected_text.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- int_to_decimal_ascii_unit.f -----
sv/itda_pkg.sv
sv/itda_front.sv
sv/itda_queue.sv
sv/itda_back.sv
sv/int_to_decimal_ascii_unit.sv
test/tb_int_to_decimal_ascii_unit.sv
